@@ rtl/core/key_matrix_scan_to_midi_notes_assert.svh @@
`ifndef KEY_MATRIX_SCAN_TO_MIDI_NOTES_ASSERT_SVH
`define KEY_MATRIX_SCAN_TO_MIDI_NOTES_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define KMSM_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define KMSM_ASSERT_NXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/core/kmsm_pkg.sv @@
package kmsm_pkg;

	// default geometry
	localparam int DEF_COLUMNS = 8;
	localparam int DEF_ROWS    = 32;
	localparam int DEF_KEYS    = 128;

	// fixed field widths
	localparam int COL_W      = 3;
	localparam int WORD_W     = 32;
	localparam int TIME_W     = 32;
	localparam int KEY_FULL_W = 7;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_W      = 8;

	// note mapping
	localparam int         MANUAL_KEYS = 64;
	localparam logic [6:0] NOTE_CEIL   = 7'd96;
	localparam logic [3:0] STATUS_ON   = 4'h9;
	localparam logic [3:0] STATUS_OFF  = 4'h8;

	// register reset values
	localparam logic       RST_CLOSED_LEVEL  = 1'b1;
	localparam logic [3:0] RST_LOWER_CHANNEL = 4'd0;
	localparam logic [3:0] RST_UPPER_CHANNEL = 4'd1;
	localparam logic [6:0] RST_ON_VELOCITY   = 7'd127;
	localparam logic [6:0] RST_OFF_VELOCITY  = 7'd0;
	localparam logic [7:0] RST_SETTLE_MS     = 8'd2;
	localparam logic [6:0] RST_BASE_NOTE     = 7'd36;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CLOSED_LEVEL  = 3'd0,
		REG_LOWER_CHANNEL = 3'd1,
		REG_UPPER_CHANNEL = 3'd2,
		REG_ON_VELOCITY   = 3'd3,
		REG_OFF_VELOCITY  = 3'd4,
		REG_SETTLE_MS     = 3'd5,
		REG_BASE_NOTE     = 3'd6
	} kmsm_reg_t;

	typedef enum logic [1:0] {
		PH_OPEN      = 2'd0,
		PH_TO_CLOSED = 2'd1,
		PH_CLOSED    = 2'd2,
		PH_TO_OPEN   = 2'd3
	} kmsm_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PICK,
		ST_EXEC,
		ST_FLUSH
	} kmsm_state_t;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [WORD_W-1:0] switch_word;
		logic [TIME_W-1:0] time_ms;
	} kmsm_in_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] note;
		logic [6:0] velocity;
		logic       last;
	} kmsm_out_t;

	// per-key debounce record
	typedef struct packed {
		kmsm_phase_t       phase;
		logic [TIME_W-1:0] stamp;
		logic              on_sent;
		logic              off_sent;
	} kmsm_rec_t;

	// what one row event asks for
	typedef struct packed {
		logic emit;
		logic note_on;
	} kmsm_act_t;

endpackage

@@ rtl/core/kmsm_key_unit.sv @@
module kmsm_key_unit import kmsm_pkg::*; (
	input  kmsm_rec_t         rec,
	input  logic              closed,
	input  logic              make_row,
	input  logic [TIME_W-1:0] now,
	input  logic [7:0]        settle_ms,
	output kmsm_rec_t         rec_next,
	output kmsm_act_t         act
);

	logic [TIME_W-1:0] age;
	logic              elapsed;
	logic              settled;

	// settle timer, wraps modulo 2^32
	assign age     = now - rec.stamp;
	assign elapsed = age >= TIME_W'(settle_ms);

	// debounce phase and sent flags
	always_comb begin
		rec_next     = rec;
		settled      = 1'b0;
		act.emit     = 1'b0;
		act.note_on  = 1'b0;
		case (rec.phase)
			PH_OPEN: begin
				if (closed) begin
					rec_next.phase = PH_TO_CLOSED;
					rec_next.stamp = now;
				end
			end
			PH_TO_CLOSED: begin
				if (elapsed) begin
					rec_next.phase = closed ? PH_CLOSED : PH_OPEN;
					settled        = closed;
				end
			end
			PH_CLOSED: begin
				if (!closed) begin
					rec_next.phase = PH_TO_OPEN;
					rec_next.stamp = now;
				end
			end
			PH_TO_OPEN: begin
				if (elapsed) begin
					rec_next.phase = closed ? PH_CLOSED : PH_OPEN;
				end
			end
			default: begin
				rec_next.phase = PH_OPEN;
			end
		endcase

		if (!make_row) begin
			// break contact closing re-arms both messages
			if (closed) begin
				rec_next.on_sent  = 1'b0;
				rec_next.off_sent = 1'b0;
			end
		end else if (closed) begin
			if (settled && !rec.on_sent) begin
				rec_next.on_sent = 1'b1;
				act.emit         = 1'b1;
				act.note_on      = 1'b1;
			end
		end else if (!rec.off_sent) begin
			rec_next.off_sent = 1'b1;
			rec_next.on_sent  = 1'b0;
			act.emit          = 1'b1;
		end
	end

endmodule

@@ rtl/core/key_matrix_scan_to_midi_notes.sv @@
// Key matrix scanner front end producing MIDI note messages.
// Scan channel (scan_valid/scan_ready/scan): one beat per scanned column,
// carrying the column index, the row switch word and a millisecond time.
// MIDI channel (midi_valid/midi_ready/midi): zero to sixteen message beats
// per column, in ascending row order, last set on the final one.
// Config port (cfg_we/cfg_addr/cfg_data): register writes, to be issued idle.
// Each changed row with a key in range passes through PICK, where its key
// record is read, and EXEC, where it is written back through the shared
// debounce unit; a changed row with a key out of range only passes PICK.
// A column with no change goes from PICK straight to FLUSH.
// Out-of-range columns are dropped in the accept cycle. Each message waits
// in a pending slot and moves to the output when the next message of the
// column is decided, the final one in the flush cycle.
// scan_ready is high only while no column is in work.
// Reset clears stored words, key valid bits and registers to defaults.
// If midi_ready stays low, the block holds at the next message to emit
// with one message in the output register and one pending behind it.
module key_matrix_scan_to_midi_notes import kmsm_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS,
	parameter int KEYS    = DEF_KEYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  scan_valid,
	output logic                  scan_ready,
	input  kmsm_in_t              scan,
	output logic                  midi_valid,
	input  logic                  midi_ready,
	output kmsm_out_t             midi,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_data
);

	`include "key_matrix_scan_to_midi_notes_assert.svh"

	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_IW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int KEY_W  = $clog2(KEYS);
	localparam int KIDX_W = (KEY_W > KEY_FULL_W) ? KEY_W : KEY_FULL_W;

	// configuration registers
	logic       closed_level_q;
	logic [3:0] lower_channel_q;
	logic [3:0] upper_channel_q;
	logic [6:0] on_velocity_q;
	logic [6:0] off_velocity_q;
	logic [7:0] settle_ms_q;
	logic [6:0] base_note_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_level_q  <= RST_CLOSED_LEVEL;
			lower_channel_q <= RST_LOWER_CHANNEL;
			upper_channel_q <= RST_UPPER_CHANNEL;
			on_velocity_q   <= RST_ON_VELOCITY;
			off_velocity_q  <= RST_OFF_VELOCITY;
			settle_ms_q     <= RST_SETTLE_MS;
			base_note_q     <= RST_BASE_NOTE;
		end else if (cfg_we) begin
			case (kmsm_reg_t'(cfg_addr))
				REG_CLOSED_LEVEL:  closed_level_q  <= cfg_data[0];
				REG_LOWER_CHANNEL: lower_channel_q <= cfg_data[3:0];
				REG_UPPER_CHANNEL: upper_channel_q <= cfg_data[3:0];
				REG_ON_VELOCITY:   on_velocity_q   <= cfg_data[6:0];
				REG_OFF_VELOCITY:  off_velocity_q  <= cfg_data[6:0];
				REG_SETTLE_MS:     settle_ms_q     <= cfg_data;
				REG_BASE_NOTE:     base_note_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	kmsm_state_t state_q, state_d;

	logic [ROWS-1:0]   prev_q [COLUMNS];
	logic [ROWS-1:0]   changed_q;
	logic [ROWS-1:0]   word_q;
	logic [TIME_W-1:0] now_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [KIDX_W-1:0] key_q;

	logic [ROWS-1:0]   word_in;
	logic [4:0]        col_ext;
	logic [COL_IW-1:0] col_idx;
	logic              col_ok;
	logic              take;

	logic [ROWS-1:0]   lsb;
	logic [ROW_W-1:0]  pick_row;
	logic [KIDX_W-1:0] key_full;
	logic              key_ok;

	logic              mem_re, mem_we, clear_bit;
	logic              out_load, out_last, out_free;
	logic              pend_load, pend_clear, pend_valid_q;
	kmsm_out_t         pend_q, msg_new, midi_q;
	logic              midi_valid_q;

	kmsm_rec_t         key_mem [KEYS];
	logic [KEYS-1:0]   valid_q;
	kmsm_rec_t         rd_q;
	logic              vrd_q;
	kmsm_rec_t         rec_cur, rec_next;
	kmsm_act_t         act;
	logic              closed;

	// input decode
	assign word_in = scan.switch_word[ROWS-1:0];
	assign col_ext = 5'(scan.column);
	assign col_idx = col_ext[COL_IW-1:0];
	assign col_ok  = 32'(scan.column) < COLUMNS;
	assign take    = scan_valid && scan_ready;

	// lowest changed row
	assign lsb = changed_q & (~changed_q + 1'b1);

	always_comb begin
		pick_row = '0;
		for (int r = 0; r < ROWS; r++) begin
			if (lsb[r]) pick_row = pick_row | ROW_W'(r);
		end
	end

	assign key_full = (KIDX_W'(pick_row >> 1) << 3) | KIDX_W'(col_q);
	assign key_ok   = 32'(key_full) < KEYS;

	// column capture and stored words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < COLUMNS; c++) prev_q[c] <= '0;
			changed_q <= '0;
		end else if (take && col_ok) begin
			prev_q[col_idx] <= word_in;
			changed_q       <= word_in ^ prev_q[col_idx];
		end else if (clear_bit) begin
			changed_q <= changed_q & ~lsb;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_q <= word_in;
			now_q  <= scan.time_ms;
			col_q  <= scan.column;
		end
		if (clear_bit) begin
			row_q <= pick_row;
			key_q <= key_full;
		end
	end

	// key record memory
	always_ff @(posedge clk) begin
		if (mem_we) key_mem[key_q[KEY_W-1:0]] <= rec_next;
		if (mem_re) rd_q <= key_mem[key_full[KEY_W-1:0]];
	end

	// record valid bits, unwritten keys read as reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vrd_q   <= 1'b0;
		end else begin
			if (mem_we) valid_q[key_q[KEY_W-1:0]] <= 1'b1;
			if (mem_re) vrd_q <= valid_q[key_full[KEY_W-1:0]];
		end
	end

	assign rec_cur = vrd_q ? rd_q : '0;
	assign closed  = word_q[row_q] == closed_level_q;

	kmsm_key_unit u_key_unit (
		.rec       (rec_cur),
		.closed    (closed),
		.make_row  (!row_q[0]),
		.now       (now_q),
		.settle_ms (settle_ms_q),
		.rec_next  (rec_next),
		.act       (act)
	);

	// message build
	always_comb begin
		logic [3:0] chan;
		logic [7:0] pitch;
		chan  = (key_q >= KIDX_W'(MANUAL_KEYS)) ? upper_channel_q : lower_channel_q;
		pitch = 8'(key_q[5:0]) + 8'(base_note_q);
		msg_new.status_byte = {act.note_on ? STATUS_ON : STATUS_OFF, chan};
		msg_new.note        = (pitch > 8'(NOTE_CEIL)) ? NOTE_CEIL : pitch[6:0];
		msg_new.velocity    = act.note_on ? on_velocity_q : off_velocity_q;
		msg_new.last        = 1'b0;
	end

	assign out_free = !midi_valid_q || midi_ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		scan_ready = 1'b0;
		mem_re     = 1'b0;
		mem_we     = 1'b0;
		clear_bit  = 1'b0;
		out_load   = 1'b0;
		out_last   = 1'b0;
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		case (state_q)
			ST_IDLE: begin
				scan_ready = 1'b1;
				if (scan_valid && col_ok) state_d = ST_PICK;
			end
			ST_PICK: begin
				if (changed_q == '0) begin
					state_d = ST_FLUSH;
				end else begin
					clear_bit = 1'b1;
					if (key_ok) begin
						mem_re  = 1'b1;
						state_d = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				if (!(act.emit && pend_valid_q && !out_free)) begin
					mem_we  = 1'b1;
					state_d = ST_PICK;
					if (act.emit) begin
						pend_load = 1'b1;
						out_load  = pend_valid_q;
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_last   = 1'b1;
					pend_clear = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// pending message, held until the next one shows it is not the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)         pend_valid_q <= 1'b0;
		else if (pend_load)  pend_valid_q <= 1'b1;
		else if (pend_clear) pend_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pend_load) pend_q <= msg_new;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)         midi_valid_q <= 1'b0;
		else if (out_load)   midi_valid_q <= 1'b1;
		else if (midi_ready) midi_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			midi_q <= {pend_q.status_byte, pend_q.note, pend_q.velocity, out_last};
		end
	end

	assign midi_valid = midi_valid_q;
	assign midi       = midi_q;

	// checks
	`KMSM_ASSERT_IMP(a_out_load_free, out_load, out_free, "output overwritten while held")
	`KMSM_ASSERT_IMP(a_idle_no_pend, state_q == ST_IDLE, !pend_valid_q, "pending beat left in idle")
	`KMSM_ASSERT_IMP(a_last_from_flush, out_load && out_last, state_q == ST_FLUSH, "last outside flush")
	`KMSM_ASSERT_NXT(a_pick_empty, state_q == ST_PICK && changed_q == '0, state_q == ST_FLUSH, "empty pick did not flush")
	`KMSM_ASSERT_NXT(a_read_then_exec, mem_re, state_q == ST_EXEC, "key read not followed by update")

endmodule
